// File: design/itad_pkg.sv
// ----------------------------------------------------------------------------
// itad_pkg: shared types and helpers for the integer to ASCII converter
// Transaction structs, mode codes, cell control bundle and character mapping.
// ----------------------------------------------------------------------------
package itad_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        OP_SDEC  = 2'd0,
        OP_UDEC  = 2'd1,
        OP_HEX   = 2'd2,
        OP_UDEC3 = 2'd3
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [IN_VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_out;

    // Control for the digit cells, applied to every cell in the same cycle.
    typedef struct packed {
        logic clr;
        logic conv;
        logic dec;
        logic move;
    } t_cell_ctl;

    // Decimal digits needed for the largest w-bit value: floor(w*log10(2))+1.
    function automatic int dec_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {4'd0, d};
        end else begin
            ch = CH_ALPHA + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// File: design/integer_to_ascii_digits_top.sv
// Output order: a minus sign is registered at accept and shown in the next cycle;
// the digits follow after the bit-serial shift through the digit cells, and the
// digits (leading zeros dropped) go out one per cycle, the final character last.
// A new transaction is accepted only in idle, after the bit-serial shift through the
// digit cells and the one-digit-per-cycle scan of the top cell have finished.
// Reset (synchronous, active low) returns the sequencer to idle with no output.
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top: integer to ASCII text converter
// Signed/unsigned decimal and lowercase hex, most significant digit first.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_top
    import itad_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_valid,
    output t_out o_result
);

    localparam int NDIG  = dec_digits(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_bits, n_bits;
    logic                   r_dec, n_dec;
    logic                   r_started, n_started;
    logic                   r_valid, n_valid;
    t_out                   r_out, n_out;

    logic [VALUE_WIDTH+IN_VALUE_W-1:0] val_ext;
    logic [VALUE_WIDTH-1:0]            val;
    logic                              neg;
    logic [3:0]                        top;
    t_cell_ctl                         ctl;
    logic                              accept;
    logic                              skip;

    assign accept  = start && (r_state == ST_IDLE);
    assign val_ext = {{VALUE_WIDTH{1'b0}}, i_in.value};
    assign val     = val_ext[VALUE_WIDTH-1:0];
    assign neg     = (i_in.op == OP_SDEC) && val[VALUE_WIDTH-1];
    // Leading zeros are dropped, but the units digit always goes out.
    assign skip    = !r_started && (top == 4'd0) && (r_cnt != CNT_W'(1));

    always_comb begin
        ctl.clr  = accept;
        ctl.conv = (r_state == ST_CONV);
        ctl.dec  = r_dec;
        ctl.move = (r_state == ST_EMIT);
    end

    itad_chain #(.NDIG(NDIG)) u_chain (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_bit (r_bits[VALUE_WIDTH-1]),
        .o_top (top)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_bits    = r_bits;
        n_dec     = r_dec;
        n_started = r_started;
        n_valid   = 1'b0;
        n_out     = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                    n_cnt   = CNT_W'(VALUE_WIDTH);
                    n_bits  = neg ? (~val + 1'b1) : val;
                    n_dec   = (i_in.op != OP_HEX);
                    if (neg) begin
                        n_valid         = 1'b1;
                        n_out.char_code = CH_MINUS;
                        n_out.last      = 1'b0;
                    end
                end
            end
            ST_CONV: begin
                n_bits = {r_bits[VALUE_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state   = ST_EMIT;
                    n_cnt     = CNT_W'(NDIG);
                    n_started = 1'b0;
                end
            end
            ST_EMIT: begin
                n_cnt = r_cnt - 1'b1;
                if (!skip) begin
                    n_started       = 1'b1;
                    n_valid         = 1'b1;
                    n_out.char_code = digit_char(top);
                    n_out.last      = (r_cnt == CNT_W'(1));
                end
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_started <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_started <= n_started;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_dec  <= n_dec;
        r_out  <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// File: design/itad_cell.sv
// ----------------------------------------------------------------------------
// itad_cell: one digit cell of the conversion chain
// Holds one 4-bit digit. In convert mode it applies the add-3 correction
// (decimal only) and shifts in a bit from its lower neighbor; in move mode it
// takes the whole digit of its lower neighbor.
// ----------------------------------------------------------------------------
module itad_cell
    import itad_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_bit,
    input  logic [3:0] i_digit,
    output logic       o_bit,
    output logic [3:0] o_digit
);

    logic [3:0] r_d;
    logic [3:0] n_d;
    logic [3:0] corr;

    assign corr    = (i_ctl.dec && r_d >= 4'd5) ? r_d + 4'd3 : r_d;
    assign o_bit   = corr[3];
    assign o_digit = r_d;

    always_comb begin
        n_d = r_d;
        priority if (i_ctl.clr) begin
            n_d = 4'd0;
        end else if (i_ctl.conv) begin
            n_d = {corr[2:0], i_bit};
        end else if (i_ctl.move) begin
            n_d = i_digit;
        end else begin
            n_d = r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

endmodule

// File: design/itad_chain.sv
// ----------------------------------------------------------------------------
// itad_chain: row of digit cells
// Cell zero is the least significant digit; the top cell feeds the output.
// ----------------------------------------------------------------------------
module itad_chain
    import itad_pkg::*;
#(
    parameter int NDIG = dec_digits(VALUE_WIDTH_DEF)
) (
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic       i_bit,
    output logic [3:0] o_top
);

    logic       carry [NDIG];
    logic [3:0] digit [NDIG+1];

    assign carry[0] = i_bit;
    assign digit[0] = 4'd0;
    assign o_top    = digit[NDIG];

    for (genvar i = 0; i < NDIG; i++) begin : g_cell
        if (i == NDIG - 1) begin : g_top
            itad_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_bit   (carry[i]),
                .i_digit (digit[i]),
                .o_bit   (),
                .o_digit (digit[i+1])
            );
        end else begin : g_mid
            itad_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_bit   (carry[i]),
                .i_digit (digit[i]),
                .o_bit   (carry[i+1]),
                .o_digit (digit[i+1])
            );
        end
    end

endmodule

// File: design/itad_checker.sv
// ----------------------------------------------------------------------------
// itad_checker: port-level checks for the integer to ASCII converter
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
module itad_checker
    import itad_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_out o_result
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // The final character ends the transaction in the same cycle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last |-> !busy)
        else $error("busy still high with the final character");

    // Any character that is not the final one belongs to a running transaction.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("non-final character outside a transaction");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.char_code == CH_MINUS)
            || (o_result.char_code >= 8'h30 && o_result.char_code <= 8'h39)
            || (o_result.char_code >= 8'h61 && o_result.char_code <= 8'h66))
        else $error("character outside the digit set");

    // The minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.char_code == CH_MINUS) |-> !o_result.last)
        else $error("minus sign marked as final character");

endmodule

bind integer_to_ascii_digits_top itad_checker u_itad_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
